/* rtl/core/sign_magnitude_word_alu_core_defines.svh */
// Assertion macros for the sign-magnitude word ALU.
`ifndef SIGN_MAGNITUDE_WORD_ALU_CORE_DEFINES_SVH
`define SIGN_MAGNITUDE_WORD_ALU_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// checked outside reset
`define SMW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define SMW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SMW_ASSERT(lbl, prop, msg)
`define SMW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/core/smw_pkg.sv */
// Shared types and codes for the sign-magnitude word ALU.
package smw_pkg;

  localparam int KindW = 3;
  localparam int OrdW  = 2;

  // operation kinds carried in tuser
  localparam logic [KindW-1:0] KIND_CMP = 3'd0;
  localparam logic [KindW-1:0] KIND_ADD = 3'd1;
  localparam logic [KindW-1:0] KIND_SUB = 3'd2;
  localparam logic [KindW-1:0] KIND_MUL = 3'd3;
  localparam logic [KindW-1:0] KIND_DIV = 3'd4;

  // compare outcomes
  localparam logic [OrdW-1:0] ORD_LESS    = 2'd0;
  localparam logic [OrdW-1:0] ORD_EQUAL   = 2'd1;
  localparam logic [OrdW-1:0] ORD_GREATER = 2'd2;

  // operations of the shared add/subtract unit
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CMP,
    OP_ADD,
    OP_SUB_AB,
    OP_SUB_BA,
    OP_MUL_STEP,
    OP_DIV_CHK,
    OP_DIV_STEP
  } op_e;

  // sequencer to datapath
  typedef struct packed {
    op_e  op;
    logic fin;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             same_sign;
    logic             ge;
  } stat_t;

endpackage

/* rtl/core/sign_magnitude_word_alu_core.sv */
// Top level of the sign-magnitude word ALU: stream ports and output register.
//
//  channel   direction  payload
//  s_axis    in         tuser: kind; tdata: a_sign, a_mag, low_mag, b_sign, b_mag
//  m_axis    out        tdata: hi_sign, hi_mag, lo_sign, lo_mag, overflow, order
//
// Compare, a same-sign add and the undefined kinds go from the first step straight to the
// done state; an add or subtract that reduces to a magnitude difference also passes
// through the swap state when the second magnitude is the larger one.
// Multiply and divide run one shift-add or shift-subtract step of the shared adder
// per magnitude bit.
// A divide overflow or a zero divisor ends at the overflow check, before any divide step.
// s_axis_tready_o is high only while the sequencer is idle; a finished result waits in
// the output register while the next item is taken in, and the sequencer holds in its
// last state while that register is full and not taken.
// Reset clears the sequencer and the output valid.
`include "sign_magnitude_word_alu_core_defines.svh"
module sign_magnitude_word_alu_core import smw_pkg::*; #(
  parameter int BYTE_BITS = 6,
  localparam int WordBits = 5 * BYTE_BITS,
  localparam int InDataW  = ((3 * WordBits + 2 + 7) / 8) * 8,
  localparam int OutDataW = ((2 * WordBits + 5 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // a_sign, a_mag, low_mag, b_sign, b_mag (from bit 0 up)
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // kind
  input  logic [KindW-1:0]    s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // hi_sign, hi_mag, lo_sign, lo_mag, overflow, order (from bit 0 up)
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int OvPos  = 2 * WordBits + 2;
  localparam int OrdPos = 2 * WordBits + 3;

  ctrl_t               ctrl;
  stat_t               stat;
  logic                out_free;
  logic                hi_sign, lo_sign, overflow;
  logic [WordBits-1:0] hi_mag, lo_mag;
  logic [OrdW-1:0]     order;
  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q;

  assign out_free = !m_valid_q || m_axis_tready_i;

  smw_seq #(
    .WordBits (WordBits)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready_o),
    .ctrl_o     (ctrl)
  );

  smw_unit #(
    .WordBits (WordBits)
  ) u_unit (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .kind_i     (s_axis_tuser_i),
    .a_sign_i   (s_axis_tdata_i[0]),
    .a_mag_i    (s_axis_tdata_i[WordBits:1]),
    .low_mag_i  (s_axis_tdata_i[2*WordBits:WordBits+1]),
    .b_sign_i   (s_axis_tdata_i[2*WordBits+1]),
    .b_mag_i    (s_axis_tdata_i[3*WordBits+1:2*WordBits+2]),
    .stat_o     (stat),
    .hi_sign_o  (hi_sign),
    .hi_mag_o   (hi_mag),
    .lo_sign_o  (lo_sign),
    .lo_mag_o   (lo_mag),
    .overflow_o (overflow),
    .order_o    (order)
  );

  // output register valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (ctrl.fin) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (ctrl.fin) begin
      m_data_q <= OutDataW'({order, overflow, lo_mag, lo_sign, hi_mag, hi_sign});
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `SMW_ASSERT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "input taken while busy")
  `SMW_ASSERT(a_valid_from_fin, $rose(m_axis_tvalid_o) |-> $past(ctrl.fin), "result without finish")
  `SMW_ASSERT(a_ov_no_order, m_axis_tvalid_o |-> (!m_data_q[OvPos] || m_data_q[OrdPos+1:OrdPos] == ORD_LESS), "overflow with order set")
  `SMW_ASSERT_ALWAYS(a_reset_clears, !rst_ni |=> !m_axis_tvalid_o, "valid during reset")

endmodule

/* rtl/core/smw_unit.sv */
// Datapath: operand registers, one shared add/subtract unit, result formatting.
module smw_unit import smw_pkg::*; #(
  parameter int WordBits = 30
) (
  input  logic                clk_i,
  input  ctrl_t               ctrl_i,
  input  logic [KindW-1:0]    kind_i,
  input  logic                a_sign_i,
  input  logic [WordBits-1:0] a_mag_i,
  input  logic [WordBits-1:0] low_mag_i,
  input  logic                b_sign_i,
  input  logic [WordBits-1:0] b_mag_i,
  output stat_t               stat_o,
  output logic                hi_sign_o,
  output logic [WordBits-1:0] hi_mag_o,
  output logic                lo_sign_o,
  output logic [WordBits-1:0] lo_mag_o,
  output logic                overflow_o,
  output logic [OrdW-1:0]     order_o
);

  logic [KindW-1:0]    kind_q;
  logic                as_q, bs_q, rsign_q, ov_q;
  logic [WordBits-1:0] am_q, bm_q, lo_q;
  logic [WordBits:0]   acc_q;
  logic [OrdW-1:0]     ord_q;

  logic [WordBits:0]   x, y;
  logic                sub;
  logic [WordBits+1:0] sum;
  logic                ge, bs_eff, sg, nz;
  logic [OrdW-1:0]     ord_d;

  assign bs_eff = bs_q ^ (kind_q == KIND_SUB);
  assign sg     = as_q ^ bs_q;

  // operand select for the shared adder
  always_comb begin
    x   = '0;
    y   = '0;
    sub = 1'b0;
    unique case (ctrl_i.op)
      OP_CMP, OP_SUB_AB, OP_DIV_CHK: begin
        x   = {1'b0, am_q};
        y   = {1'b0, bm_q};
        sub = 1'b1;
      end
      OP_SUB_BA: begin
        x   = {1'b0, bm_q};
        y   = {1'b0, am_q};
        sub = 1'b1;
      end
      OP_ADD: begin
        x = {1'b0, am_q};
        y = {1'b0, bm_q};
      end
      OP_MUL_STEP: begin
        x = acc_q;
        y = bm_q[0] ? {1'b0, am_q} : '0;
      end
      OP_DIV_STEP: begin
        x   = {acc_q[WordBits-1:0], lo_q[WordBits-1]};
        y   = {1'b0, bm_q};
        sub = 1'b1;
      end
      default: begin
        x   = '0;
        y   = '0;
        sub = 1'b0;
      end
    endcase
  end

  // shared adder; top carry is "no borrow" on subtract
  assign sum = {1'b0, x} + {1'b0, y ^ {(WordBits+1){sub}}} + {{(WordBits+1){1'b0}}, sub};
  assign ge  = sum[WordBits+1];
  assign nz  = (sum[WordBits:0] != '0);

  // compare outcome
  always_comb begin
    if (am_q == '0 && bm_q == '0) begin
      ord_d = ORD_EQUAL;
    end else if (as_q != bs_q) begin
      ord_d = as_q ? ORD_LESS : ORD_GREATER;
    end else if (ge && !nz) begin
      ord_d = ORD_EQUAL;
    end else if (ge ^ as_q) begin
      ord_d = ORD_GREATER;
    end else begin
      ord_d = ORD_LESS;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_LOAD: begin
        kind_q  <= kind_i;
        as_q    <= a_sign_i;
        bs_q    <= b_sign_i;
        am_q    <= a_mag_i;
        bm_q    <= b_mag_i;
        lo_q    <= low_mag_i;
        acc_q   <= (kind_i == KIND_DIV) ? {1'b0, a_mag_i} : '0;
        ov_q    <= 1'b0;
        rsign_q <= 1'b0;
        ord_q   <= ORD_LESS;
      end
      OP_CMP: begin
        ord_q <= ord_d;
      end
      OP_ADD: begin
        acc_q   <= {1'b0, sum[WordBits-1:0]};
        ov_q    <= sum[WordBits];
        rsign_q <= as_q;
      end
      OP_SUB_AB: begin
        if (ge) begin
          acc_q   <= {1'b0, sum[WordBits-1:0]};
          rsign_q <= as_q;
        end
      end
      OP_SUB_BA: begin
        acc_q   <= {1'b0, sum[WordBits-1:0]};
        rsign_q <= bs_eff;
      end
      OP_MUL_STEP: begin
        acc_q <= {1'b0, sum[WordBits:1]};
        lo_q  <= {sum[0], lo_q[WordBits-1:1]};
        bm_q  <= {1'b0, bm_q[WordBits-1:1]};
      end
      OP_DIV_CHK: begin
        ov_q <= ge;
      end
      OP_DIV_STEP: begin
        acc_q <= ge ? sum[WordBits:0] : x;
        lo_q  <= {lo_q[WordBits-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  assign stat_o.kind      = kind_q;
  assign stat_o.same_sign = (as_q == bs_eff);
  assign stat_o.ge        = ge;

  // result fields by kind
  always_comb begin
    hi_sign_o  = 1'b0;
    hi_mag_o   = '0;
    lo_sign_o  = 1'b0;
    lo_mag_o   = '0;
    overflow_o = 1'b0;
    order_o    = ORD_LESS;
    unique case (kind_q)
      KIND_CMP: begin
        order_o = ord_q;
      end
      KIND_ADD, KIND_SUB: begin
        hi_sign_o  = rsign_q;
        hi_mag_o   = acc_q[WordBits-1:0];
        overflow_o = ov_q;
      end
      KIND_MUL: begin
        hi_sign_o = sg;
        hi_mag_o  = acc_q[WordBits-1:0];
        lo_sign_o = sg;
        lo_mag_o  = lo_q;
      end
      KIND_DIV: begin
        hi_sign_o  = sg;
        lo_sign_o  = as_q;
        overflow_o = ov_q;
        if (!ov_q) begin
          hi_mag_o = lo_q;
          lo_mag_o = acc_q[WordBits-1:0];
        end
      end
      default: begin
        hi_sign_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/smw_seq.sv */
// Sequencer: steps the shared unit through one operation.
module smw_seq import smw_pkg::*; #(
  parameter int WordBits = 30
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_free_i,
  input  stat_t stat_i,
  output logic  in_ready_o,
  output ctrl_t ctrl_o
);

  localparam int CntW = $clog2(WordBits + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_SWAP  = 3'd2;
  localparam logic [2:0] ST_ITER  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // next state and unit operation
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    ctrl_o.op   = OP_NONE;
    ctrl_o.fin  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.op = OP_LOAD;
          state_d   = ST_FIRST;
        end
      end
      ST_FIRST: begin
        unique case (stat_i.kind)
          KIND_CMP: begin
            ctrl_o.op = OP_CMP;
            state_d   = ST_DONE;
          end
          KIND_ADD, KIND_SUB: begin
            if (stat_i.same_sign) begin
              ctrl_o.op = OP_ADD;
              state_d   = ST_DONE;
            end else begin
              ctrl_o.op = OP_SUB_AB;
              state_d   = stat_i.ge ? ST_DONE : ST_SWAP;
            end
          end
          KIND_MUL: begin
            cnt_d   = CntW'(WordBits);
            state_d = ST_ITER;
          end
          KIND_DIV: begin
            ctrl_o.op = OP_DIV_CHK;
            cnt_d     = CntW'(WordBits);
            state_d   = stat_i.ge ? ST_DONE : ST_ITER;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_SWAP: begin
        ctrl_o.op = OP_SUB_BA;
        state_d   = ST_DONE;
      end
      ST_ITER: begin
        ctrl_o.op = (stat_i.kind == KIND_MUL) ? OP_MUL_STEP : OP_DIV_STEP;
        cnt_d     = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          ctrl_o.fin = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* verif/word_result_checker.sv */
// Result checker for the sign-magnitude word ALU: predicts each result and compares it.
`timescale 1ns / 100ps
module word_result_checker import smw_pkg::*; #(
  parameter int BYTE_BITS = 6,
  localparam int WordBits = 5 * BYTE_BITS,
  localparam int InDataW  = ((3 * WordBits + 2 + 7) / 8) * 8,
  localparam int OutDataW = ((2 * WordBits + 5 + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_tvalid_i,
  input  logic                in_tready_i,
  // a_sign, a_mag, low_mag, b_sign, b_mag (from bit 0 up)
  input  logic [InDataW-1:0]  in_tdata_i,
  // kind
  input  logic [KindW-1:0]    in_tuser_i,
  input  logic                out_tvalid_i,
  input  logic                out_tready_i,
  // hi_sign, hi_mag, lo_sign, lo_mag, overflow, order (from bit 0 up)
  input  logic [OutDataW-1:0] out_tdata_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  results_o
);

  localparam int W = WordBits;

  typedef struct packed {
    logic          hi_sign;
    logic [W-1:0]  hi_mag;
    logic          lo_sign;
    logic [W-1:0]  lo_mag;
    logic          overflow;
    logic [OrdW-1:0] order;
  } word_result_t;

  word_result_t expected_results[$];
  int           mismatches = 0;
  int           outstanding = 0;
  int           checked = 0;

  assign errors_o  = mismatches;
  assign pending_o = outstanding;
  assign results_o = checked;

  // Bit-exact prediction of one ALU operation.
  function automatic word_result_t compute_word_result(
    input logic [KindW-1:0] kind,
    input logic             a_sign,
    input logic [W-1:0]     a_mag,
    input logic [W-1:0]     low_mag,
    input logic             b_sign,
    input logic [W-1:0]     b_mag
  );
    word_result_t   r;
    logic [W:0]     sum;
    logic [2*W-1:0] wide;
    logic [2*W-1:0] quot;
    logic [2*W-1:0] rem;
    logic           b_eff;
    r = '0;
    case (kind)
      KIND_CMP: begin
        if (a_mag == '0 && b_mag == '0) begin
          r.order = ORD_EQUAL;
        end else if (a_sign != b_sign) begin
          r.order = a_sign ? ORD_LESS : ORD_GREATER;
        end else if (a_mag == b_mag) begin
          r.order = ORD_EQUAL;
        end else begin
          // larger magnitude wins unless both are negative
          r.order = ((a_mag > b_mag) ^ a_sign) ? ORD_GREATER : ORD_LESS;
        end
      end
      KIND_ADD, KIND_SUB: begin
        b_eff = (kind == KIND_SUB) ? ~b_sign : b_sign;
        if (a_sign == b_eff) begin
          sum = {1'b0, a_mag} + {1'b0, b_mag};
          r.hi_sign  = a_sign;
          r.hi_mag   = sum[W-1:0];
          r.overflow = sum[W];
        end else if (a_mag >= b_mag) begin
          // tie gives zero with the first operand's sign
          r.hi_sign = a_sign;
          r.hi_mag  = a_mag - b_mag;
        end else begin
          r.hi_sign = b_eff;
          r.hi_mag  = b_mag - a_mag;
        end
      end
      KIND_MUL: begin
        wide = {{W{1'b0}}, a_mag} * {{W{1'b0}}, b_mag};
        r.hi_sign = a_sign ^ b_sign;
        r.lo_sign = a_sign ^ b_sign;
        r.hi_mag  = wide[2*W-1:W];
        r.lo_mag  = wide[W-1:0];
      end
      KIND_DIV: begin
        r.hi_sign = a_sign ^ b_sign;
        r.lo_sign = a_sign;
        if (a_mag >= b_mag) begin
          // quotient would not fit, zero divisor included
          r.overflow = 1'b1;
        end else begin
          wide = {a_mag, low_mag};
          quot = wide / {{W{1'b0}}, b_mag};
          rem  = wide % {{W{1'b0}}, b_mag};
          r.hi_mag = quot[W-1:0];
          r.lo_mag = rem[W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("checker: result %0d, %s: expected 0x%0h, got 0x%0h",
             checked, field, want, got);
    mismatches++;
  endtask

  // Predict on each input transfer, compare on each output transfer.
  always @(posedge clk_i) begin
    word_result_t want;
    word_result_t got;
    if (rst_ni) begin
      if (in_tvalid_i && in_tready_i) begin
        expected_results.push_back(compute_word_result(
          in_tuser_i, in_tdata_i[0], in_tdata_i[W:1], in_tdata_i[2*W:W+1],
          in_tdata_i[2*W+1], in_tdata_i[3*W+1:2*W+2]));
      end
      if (out_tvalid_i && out_tready_i) begin
        got.hi_sign  = out_tdata_i[0];
        got.hi_mag   = out_tdata_i[W:1];
        got.lo_sign  = out_tdata_i[W+1];
        got.lo_mag   = out_tdata_i[2*W+1:W+2];
        got.overflow = out_tdata_i[2*W+2];
        got.order    = out_tdata_i[2*W+4:2*W+3];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, 64'(out_tdata_i));
        end else begin
          want = expected_results.pop_front();
          if (got.hi_sign != want.hi_sign)
            report_mismatch("hi_sign", 64'(want.hi_sign), 64'(got.hi_sign));
          if (got.hi_mag != want.hi_mag)
            report_mismatch("hi_mag", 64'(want.hi_mag), 64'(got.hi_mag));
          if (got.lo_sign != want.lo_sign)
            report_mismatch("lo_sign", 64'(want.lo_sign), 64'(got.lo_sign));
          if (got.lo_mag != want.lo_mag)
            report_mismatch("lo_mag", 64'(want.lo_mag), 64'(got.lo_mag));
          if (got.overflow != want.overflow)
            report_mismatch("overflow", 64'(want.overflow), 64'(got.overflow));
          if (got.order != want.order)
            report_mismatch("order", 64'(want.order), 64'(got.order));
        end
        checked <= checked + 1;
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

/* verif/testbench.sv */
// Testbench top for the sign-magnitude word ALU: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import smw_pkg::*;

  localparam int BYTE_BITS = 6;
  localparam int W         = 5 * BYTE_BITS;
  localparam int InDataW   = ((3 * W + 2 + 7) / 8) * 8;
  localparam int OutDataW  = ((2 * W + 5 + 7) / 8) * 8;
  localparam int RandomOps = 1150;
  localparam int IdlePct   = 29;
  localparam int StallLimit = 3000;
  localparam int DrainCycles = 40;

  // kinds past divide produce an all-zero result
  localparam logic [KindW-1:0] KIND_UNDEF_FIRST = 3'd5;
  localparam logic [KindW-1:0] KIND_UNDEF_LAST  = 3'd7;

  localparam logic [W-1:0] MAG_MAX = {W{1'b1}};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [InDataW-1:0]  in_data = '0;
  logic [KindW-1:0]    in_user = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OutDataW-1:0] out_data;

  int  fail_count;
  int  pending;
  int  results;
  bit  steady = 1'b0;
  int  sent_by_kind[8];
  int  idle_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  sign_magnitude_word_alu_core #(.BYTE_BITS(BYTE_BITS)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_data),
    .s_axis_tuser_i (in_user),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data)
  );

  word_result_checker #(.BYTE_BITS(BYTE_BITS)) result_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (in_valid),
    .in_tready_i (in_ready),
    .in_tdata_i  (in_data),
    .in_tuser_i  (in_user),
    .out_tvalid_i(out_valid),
    .out_tready_i(out_ready),
    .out_tdata_i (out_data),
    .errors_o    (fail_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  // Result side: random back-pressure, none during the steady window.
  always @(negedge clk_i) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: timeout after %0d cycles without a transfer", StallLimit);
    $display("testbench: FAIL");
    $finish;
  end

  // Drive one operation at the falling edge and hold it until the transfer.
  task automatic send_op(input logic [KindW-1:0] kind, input logic a_sign,
                         input logic [W-1:0] a_mag, input logic [W-1:0] low_mag,
                         input logic b_sign, input logic [W-1:0] b_mag);
    logic [InDataW-1:0] packed_data;
    packed_data = '0;
    packed_data[0]             = a_sign;
    packed_data[W:1]           = a_mag;
    packed_data[2*W:W+1]       = low_mag;
    packed_data[2*W+1]         = b_sign;
    packed_data[3*W+1:2*W+2]   = b_mag;
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_user  <= kind;
    in_data  <= packed_data;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent_by_kind[kind]++;
    @(negedge clk_i);
  endtask

  // Magnitude biased toward the edges.
  function automatic logic [W-1:0] rand_mag();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return MAG_MAX;
      2: return W'(1);
      3: return MAG_MAX - W'(1);
      4: return W'($urandom_range(0, 255));
      default: return W'($urandom);
    endcase
  endfunction

  initial begin
    logic [KindW-1:0] kind;
    logic [W-1:0]     am;
    logic [W-1:0]     bm;
    int               pick;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: compare corners
    send_op(KIND_CMP, 1'b0, '0, '0, 1'b1, '0);            // +0 equals -0
    send_op(KIND_CMP, 1'b0, W'(1), '0, 1'b1, MAG_MAX);
    send_op(KIND_CMP, 1'b1, MAG_MAX, '0, 1'b1, W'(1));
    send_op(KIND_CMP, 1'b0, MAG_MAX, '0, 1'b0, MAG_MAX);
    send_op(KIND_CMP, 1'b1, '0, MAG_MAX, 1'b0, W'(1));
    // add and subtract: carry out, ties, larger second magnitude
    send_op(KIND_ADD, 1'b0, MAG_MAX, '0, 1'b0, MAG_MAX);
    send_op(KIND_ADD, 1'b1, MAG_MAX, '0, 1'b1, W'(1));
    send_op(KIND_ADD, 1'b1, W'(12345), '0, 1'b0, W'(12345));
    send_op(KIND_ADD, 1'b0, W'(1), '0, 1'b1, MAG_MAX);
    send_op(KIND_SUB, 1'b0, W'(777), '0, 1'b0, W'(777));
    send_op(KIND_SUB, 1'b1, W'(5), '0, 1'b1, MAG_MAX);
    send_op(KIND_SUB, 1'b0, MAG_MAX, '0, 1'b1, MAG_MAX);
    // multiply corners
    send_op(KIND_MUL, 1'b0, MAG_MAX, '0, 1'b0, MAG_MAX);
    send_op(KIND_MUL, 1'b1, '0, '0, 1'b0, MAG_MAX);
    send_op(KIND_MUL, 1'b1, MAG_MAX, '0, 1'b1, W'(1));
    // divide: normal, zero divisor, high word equal to divisor
    send_op(KIND_DIV, 1'b0, MAG_MAX - W'(1), MAG_MAX, 1'b1, MAG_MAX);
    send_op(KIND_DIV, 1'b1, '0, MAG_MAX, 1'b0, W'(1));
    send_op(KIND_DIV, 1'b1, '0, W'(1), 1'b1, '0);
    send_op(KIND_DIV, 1'b0, W'(4242), '0, 1'b1, W'(4242));
    send_op(KIND_DIV, 1'b1, '0, MAG_MAX, 1'b0, MAG_MAX);
    // undefined kinds
    for (int k = int'(KIND_UNDEF_FIRST); k <= int'(KIND_UNDEF_LAST); k++)
      send_op(k[KindW-1:0], 1'b1, MAG_MAX, MAG_MAX, 1'b1, MAG_MAX);

    // random operations, with a window of back-to-back traffic
    for (int n = 0; n < RandomOps; n++) begin
      steady = (n >= 450 && n < 650);
      pick = $urandom_range(0, 99);
      kind = (pick < 2) ? KindW'($urandom_range(KIND_UNDEF_FIRST, KIND_UNDEF_LAST))
                        : KindW'($urandom_range(KIND_CMP, KIND_DIV));
      am = rand_mag();
      bm = rand_mag();
      if (kind == KIND_CMP && $urandom_range(0, 3) == 0) begin
        bm = am;
      end else if (kind == KIND_DIV && $urandom_range(0, 4) != 0) begin
        // keep the quotient in range most of the time
        am = (bm == '0) ? '0 : W'($urandom % bm);
      end
      send_op(kind, 1'($urandom), am, rand_mag(), 1'($urandom), bm);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("testbench: %0d operations sent, %0d results checked", 
             sent_by_kind.sum(), results);
    $display("testbench: cmp %0d add %0d sub %0d mul %0d div %0d undefined %0d",
             sent_by_kind[KIND_CMP], sent_by_kind[KIND_ADD], sent_by_kind[KIND_SUB],
             sent_by_kind[KIND_MUL], sent_by_kind[KIND_DIV],
             sent_by_kind[KIND_UNDEF_FIRST] + sent_by_kind[KIND_UNDEF_FIRST + 3'd1]
             + sent_by_kind[KIND_UNDEF_LAST]);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/smw_pkg.sv
rtl/core/smw_unit.sv
rtl/core/smw_seq.sv
rtl/core/sign_magnitude_word_alu_core.sv
verif/word_result_checker.sv
verif/testbench.sv
